[rtl/ppfl_pkg.sv]
package ppfl_pkg;

    // Default sizes, handed to the top level parameters
    localparam int NUM_CPUS_DEF   = 8;
    localparam int MAX_PAGES_DEF  = 32768;
    localparam int PAGE_SHIFT_DEF = 12;

    // Field widths fixed by the interface
    localparam int CPU_FIELD_W = 3;
    localparam int ADDR_W      = 32;
    localparam int LINK_W      = 16;
    localparam int COUNT_W     = 16;
    localparam int FIRST_W     = 20;
    localparam int END_W       = 21;

    // Head value of an empty list
    localparam logic [LINK_W-1:0] EMPTY_MARK = 16'hFFFF;

    // Reset values of the configuration registers
    localparam logic [FIRST_W-1:0] FIRST_PAGE_RST = 20'd524288;
    localparam logic [END_W-1:0]   END_PAGE_RST   = 21'd557056;

    // Configuration register indexes
    localparam logic CFG_FIRST_PAGE = 1'b0;
    localparam logic CFG_END_PAGE   = 1'b1;

    // Request opcodes
    localparam logic OP_FREE  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Command queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    // What the front end decided about a request
    typedef enum logic [2:0] {
        K_PUSH        = 3'd0,
        K_POP         = 3'd1,
        K_BAD_FREE    = 3'd2,
        K_NOCPU_FREE  = 3'd3,
        K_NOCPU_ALLOC = 3'd4
    } kind_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_POP  = 1'b1
    } bstate_t;

    typedef struct packed {
        logic                   op;
        logic [CPU_FIELD_W-1:0] cpu;
        logic [ADDR_W-1:0]      address;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  page_address;
        logic [COUNT_W-1:0] free_count;
    } rsp_t;

    typedef struct packed {
        kind_t                  kind;
        logic [CPU_FIELD_W-1:0] cpu;
        logic [LINK_W-1:0]      offset;
    } qent_t;

endpackage

[rtl/ppfl_front.sv]
module ppfl_front #(
    parameter int NUM_CPUS   = ppfl_pkg::NUM_CPUS_DEF,
    parameter int MAX_PAGES  = ppfl_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = ppfl_pkg::PAGE_SHIFT_DEF
) (
    input  logic                          req_valid,
    input  ppfl_pkg::req_t                req,
    output logic                          req_stall,
    input  logic [ppfl_pkg::FIRST_W-1:0]  first_page,
    input  logic [ppfl_pkg::END_W-1:0]    end_page,
    output logic                          q_push,
    output ppfl_pkg::qent_t               q_ent,
    input  logic                          q_ready
);

    localparam int CMP_W = ppfl_pkg::ADDR_W + 1;
    localparam int CPUC_W = 7;

    logic             aligned;
    logic [CMP_W-1:0] page;
    logic [CMP_W-1:0] first_ext;
    logic [CMP_W-1:0] end_ext;
    logic [CMP_W-1:0] offset_full;
    logic             in_window;
    logic             cpu_ok;

    // Address checks for a free: alignment and page window
    assign aligned     = (req.address & ((ppfl_pkg::ADDR_W)'(1) << PAGE_SHIFT) - 1'b1) == '0;
    assign page        = CMP_W'(req.address >> PAGE_SHIFT);
    assign first_ext   = CMP_W'(first_page);
    assign end_ext     = CMP_W'(end_page);
    assign offset_full = page - first_ext;
    assign in_window   = aligned && (page >= first_ext) && (page < end_ext)
                         && (offset_full < CMP_W'(MAX_PAGES));
    assign cpu_ok      = CPUC_W'(req.cpu) < CPUC_W'(NUM_CPUS);

    // Classify the request
    always_comb
    begin
        q_ent.cpu    = req.cpu;
        q_ent.offset = offset_full[ppfl_pkg::LINK_W-1:0];
        if (!cpu_ok)
        begin
            q_ent.kind = (req.op == ppfl_pkg::OP_ALLOC) ? ppfl_pkg::K_NOCPU_ALLOC
                                                        : ppfl_pkg::K_NOCPU_FREE;
        end
        else if (req.op == ppfl_pkg::OP_ALLOC)
        begin
            q_ent.kind = ppfl_pkg::K_POP;
        end
        else if (in_window)
        begin
            q_ent.kind = ppfl_pkg::K_PUSH;
        end
        else
        begin
            q_ent.kind = ppfl_pkg::K_BAD_FREE;
        end
    end

    assign q_push    = req_valid && q_ready;
    assign req_stall = !q_ready;

endmodule

[rtl/ppfl_queue.sv]
module ppfl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ppfl_pkg::qent_t push_ent,
    output logic            ready,
    output logic            valid,
    output ppfl_pkg::qent_t head_ent,
    input  logic            pop
);

    ppfl_pkg::qent_t                 slot_reg [ppfl_pkg::Q_DEPTH];
    logic [ppfl_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [ppfl_pkg::Q_PTR_W-1:0]    wr_ptr_next;
    logic [ppfl_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [ppfl_pkg::Q_PTR_W-1:0]    rd_ptr_next;
    logic [ppfl_pkg::Q_CNT_W-1:0]    cnt_reg;
    logic [ppfl_pkg::Q_CNT_W-1:0]    cnt_next;
    logic                            do_push;
    logic                            do_pop;

    assign ready    = cnt_reg != ppfl_pkg::Q_CNT_W'(ppfl_pkg::Q_DEPTH);
    assign valid    = cnt_reg != '0;
    assign head_ent = slot_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

[rtl/ppfl_back.sv]
module ppfl_back #(
    parameter int NUM_CPUS   = ppfl_pkg::NUM_CPUS_DEF,
    parameter int MAX_PAGES  = ppfl_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = ppfl_pkg::PAGE_SHIFT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  ppfl_pkg::qent_t              q_ent,
    output logic                         q_pop,
    input  logic [ppfl_pkg::FIRST_W-1:0] first_page,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output ppfl_pkg::rsp_t               rsp
);

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int MEM_AW = $clog2(MAX_PAGES);
    localparam int SUM_W  = ppfl_pkg::FIRST_W + 1;

    ppfl_pkg::bstate_t              state_reg;
    ppfl_pkg::bstate_t              state_next;
    logic [ppfl_pkg::LINK_W-1:0]    head_reg [NUM_CPUS];
    logic [ppfl_pkg::COUNT_W-1:0]   cnt_reg  [NUM_CPUS];
    logic [ppfl_pkg::LINK_W-1:0]    link_mem [MAX_PAGES];
    logic [ppfl_pkg::LINK_W-1:0]    rd_data_reg;
    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    ppfl_pkg::rsp_t                 rsp_reg;
    ppfl_pkg::rsp_t                 rsp_next;

    logic [CPU_W-1:0]               cidx;
    logic [ppfl_pkg::LINK_W-1:0]    cur_head;
    logic [ppfl_pkg::COUNT_W-1:0]   cur_cnt;
    logic                           head_empty;
    logic                           out_free;
    logic                           done;
    logic                           rd_en;
    logic                           wr_en;
    logic                           list_we;
    logic [ppfl_pkg::LINK_W-1:0]    head_wdata;
    logic [ppfl_pkg::COUNT_W-1:0]   cnt_wdata;
    logic [ppfl_pkg::COUNT_W-1:0]   cnt_inc;
    logic [ppfl_pkg::COUNT_W-1:0]   cnt_dec;
    logic [SUM_W-1:0]               page_sum;
    logic [ppfl_pkg::ADDR_W-1:0]    pop_addr;

    assign cidx       = CPU_W'(q_ent.cpu);
    assign cur_head   = head_reg[cidx];
    assign cur_cnt    = cnt_reg[cidx];
    assign head_empty = cur_head >= ppfl_pkg::LINK_W'(MAX_PAGES);
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign cnt_inc    = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
    assign cnt_dec    = (cur_cnt == '0) ? cur_cnt : cur_cnt - 1'b1;
    assign page_sum   = SUM_W'(first_page) + SUM_W'(cur_head);
    assign pop_addr   = ppfl_pkg::ADDR_W'(page_sum) << PAGE_SHIFT;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppfl_pkg::BK_IDLE:
            begin
                if (q_valid && (q_ent.kind == ppfl_pkg::K_POP) && !head_empty)
                begin
                    state_next = ppfl_pkg::BK_POP;
                end
            end
            ppfl_pkg::BK_POP:
            begin
                if (out_free)
                begin
                    state_next = ppfl_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ppfl_pkg::BK_IDLE;
            end
        endcase
    end

    // Per-state actions: link store access, list update, result
    always_comb
    begin
        done                  = 1'b0;
        rd_en                 = 1'b0;
        wr_en                 = 1'b0;
        list_we               = 1'b0;
        head_wdata            = cur_head;
        cnt_wdata             = cur_cnt;
        rsp_next.status       = ppfl_pkg::ST_OK;
        rsp_next.page_address = '0;
        rsp_next.free_count   = cur_cnt;
        case (state_reg)
            ppfl_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_ent.kind)
                        ppfl_pkg::K_PUSH:
                        begin
                            if (out_free)
                            begin
                                done                = 1'b1;
                                wr_en               = 1'b1;
                                list_we             = 1'b1;
                                head_wdata          = q_ent.offset;
                                cnt_wdata           = cnt_inc;
                                rsp_next.free_count = cnt_inc;
                            end
                        end
                        ppfl_pkg::K_POP:
                        begin
                            if (!head_empty)
                            begin
                                rd_en = 1'b1;
                            end
                            else if (out_free)
                            begin
                                done            = 1'b1;
                                rsp_next.status = ppfl_pkg::ST_EMPTY;
                            end
                        end
                        ppfl_pkg::K_BAD_FREE:
                        begin
                            done            = out_free;
                            rsp_next.status = ppfl_pkg::ST_BAD;
                        end
                        ppfl_pkg::K_NOCPU_FREE:
                        begin
                            done                = out_free;
                            rsp_next.status     = ppfl_pkg::ST_BAD;
                            rsp_next.free_count = '0;
                        end
                        ppfl_pkg::K_NOCPU_ALLOC:
                        begin
                            done                = out_free;
                            rsp_next.status     = ppfl_pkg::ST_EMPTY;
                            rsp_next.free_count = '0;
                        end
                        default:
                        begin
                            done = 1'b0;
                        end
                    endcase
                end
            end
            ppfl_pkg::BK_POP:
            begin
                if (out_free)
                begin
                    done                  = 1'b1;
                    list_we               = 1'b1;
                    head_wdata            = rd_data_reg;
                    cnt_wdata             = cnt_dec;
                    rsp_next.page_address = pop_addr;
                    rsp_next.free_count   = cnt_dec;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign q_pop          = done;
    assign rsp_valid_next = done || (rsp_valid_reg && rsp_stall);

    // Control and list registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppfl_pkg::BK_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                head_reg[i] <= ppfl_pkg::EMPTY_MARK;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (list_we)
            begin
                head_reg[cidx] <= head_wdata;
                cnt_reg[cidx]  <= cnt_wdata;
            end
        end
    end

    // Result beat register
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Link store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[q_ent.offset[MEM_AW-1:0]] <= cur_head;
        end
        if (rd_en)
        begin
            rd_data_reg <= link_mem[cur_head[MEM_AW-1:0]];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/per_cpu_page_free_list.sv]
// Per-CPU LIFO page free lists linked through a link store with a registered read port.
// A free or a rejected request goes from the head of the command queue straight into the
// result register; an allocate first passes through the registered link store read.
// One free per cycle unless the result stalls; an allocate is done before the next command.
// Reset clears all list heads to empty and all counts to zero; the link store is not cleared.
module per_cpu_page_free_list #(
    parameter int NUM_CPUS   = ppfl_pkg::NUM_CPUS_DEF,
    parameter int MAX_PAGES  = ppfl_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = ppfl_pkg::PAGE_SHIFT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  ppfl_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output ppfl_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [ppfl_pkg::END_W-1:0] cfg_data
);

    logic [ppfl_pkg::FIRST_W-1:0] first_page_reg;
    logic [ppfl_pkg::END_W-1:0]   end_page_reg;
    logic                         q_push;
    logic                         q_ready;
    logic                         q_valid;
    logic                         q_pop;
    ppfl_pkg::qent_t              q_in;
    ppfl_pkg::qent_t              q_head;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg <= ppfl_pkg::FIRST_PAGE_RST;
            end_page_reg   <= ppfl_pkg::END_PAGE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ppfl_pkg::CFG_FIRST_PAGE)
            begin
                first_page_reg <= cfg_data[ppfl_pkg::FIRST_W-1:0];
            end
            else
            begin
                end_page_reg <= cfg_data;
            end
        end
    end

    // Front end: checks and classifies each request
    ppfl_front #(
        .NUM_CPUS   (NUM_CPUS),
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .req_valid  (req_valid),
        .req        (req),
        .req_stall  (req_stall),
        .first_page (first_page_reg),
        .end_page   (end_page_reg),
        .q_push     (q_push),
        .q_ent      (q_in),
        .q_ready    (q_ready)
    );

    // Command queue between the two halves
    ppfl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_ent (q_in),
        .ready    (q_ready),
        .valid    (q_valid),
        .head_ent (q_head),
        .pop      (q_pop)
    );

    // Back end: list updates and result beats
    ppfl_back #(
        .NUM_CPUS   (NUM_CPUS),
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ent      (q_head),
        .q_pop      (q_pop),
        .first_page (first_page_reg),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule
